// File: rtl/dam_pkg.sv
package dam_pkg;

    localparam int DAM_WORDS = 16;
    localparam int DAM_WIDTH = 16;

    typedef enum logic [2:0] {
        OP_RD_WORD  = 3'd0,
        OP_WR_WORD  = 3'd1,
        OP_RD_SLICE = 3'd2,
        OP_WR_SLICE = 3'd3,
        OP_LOGIC    = 3'd4,
        OP_KEY      = 3'd5,
        OP_MATCH    = 3'd6,
        OP_ADD      = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        FN_ZERO   = 2'd0,
        FN_COPY   = 2'd1,
        FN_INVERT = 2'd2,
        FN_ONES   = 2'd3
    } t_func;

    typedef logic [DAM_WIDTH-1:0] t_word;

    typedef struct packed {
        t_op        operation;
        t_func      func;
        logic [3:0] index;
        logic [3:0] src_index;
        t_word      data;
        logic [2:0] key;
    } t_cmd;

    typedef struct packed {
        t_word      result_data;
        logic [3:0] result_index;
        logic       found;
    } t_result;

    function automatic logic [4:0] f_popcount(input t_word w);
        logic [4:0] c;
        c = '0;
        for (int b = 0; b < DAM_WIDTH; b++) begin
            c = c + 5'(w[b]);
        end
        return c;
    endfunction

    function automatic t_word f_logic(input t_func fn, input t_word s);
        t_word v;
        case (fn)
            FN_ZERO:   v = '0;
            FN_COPY:   v = s;
            FN_INVERT: v = ~s;
            FN_ONES:   v = '1;
            default:   v = '0;
        endcase
        return v;
    endfunction

    function automatic t_word f_field_add(input t_word d);
        logic [4:0] sum;
        sum = {1'b0, d[12:9]} + {1'b0, d[8:5]};
        return {d[15:5], sum};
    endfunction

endpackage

// File: rtl/diagonal_associative_memory_unit.sv
// A command is taken at a clock edge where i_start is high and o_busy is low. The sixteen
// words sit in a ring of cells that rotates one word per cycle while a command runs, past a
// single compare and update stage, so every command takes one full turn of the ring, or two
// for a logic function, which reads the source word on the first turn and writes the target
// on the second. The result beat is on o_result for exactly one cycle with o_valid high,
// in the cycle after the last turn ends; o_busy is already low in that cycle, so the next
// command may start then. The receiver cannot hold a result off and must take it when
// o_valid is high.
module diagonal_associative_memory_unit
    import dam_pkg::*;
#(
    parameter int WORDS = DAM_WORDS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);

    t_word w_cell [WORDS];
    t_word w_tail;
    logic  w_shift;

    for (genvar g = 0; g < WORDS; g++) begin : g_cell
        t_word w_in;
        if (g == WORDS - 1) begin : g_last
            assign w_in = w_tail;
        end else begin : g_mid
            assign w_in = w_cell[g+1];
        end
        dam_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_word  (w_in),
            .o_word  (w_cell[g])
        );
    end

    dam_ctrl #(
        .WORDS (WORDS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .i_head   (w_cell[0]),
        .o_tail   (w_tail),
        .o_shift  (w_shift),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// File: rtl/dam_cell.sv
module dam_cell
    import dam_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_word i_word,
    output t_word o_word
);

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule

// File: rtl/dam_ctrl.sv
module dam_ctrl
    import dam_pkg::*;
#(
    parameter int WORDS = DAM_WORDS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    input  t_word   i_head,
    output t_word   o_tail,
    output logic    o_shift,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);

    localparam int CW = $clog2(WORDS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state     r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic       r_pass, n_pass;
    t_cmd       r_cmd, n_cmd;
    t_word      r_src, n_src;
    t_word      r_acc, n_acc;
    logic       r_hit, n_hit;
    logic [3:0] r_hit_idx, n_hit_idx;
    t_word      r_hit_word, n_hit_word;
    logic [4:0] r_best_cnt, n_best_cnt;
    logic [3:0] r_best_idx, n_best_idx;
    t_word      r_best_word, n_best_word;
    logic       r_valid, n_valid;
    t_result    r_result, n_result;

    logic       w_last;
    logic       w_at_idx;
    t_word      w_logic;
    t_word      w_add;
    logic [4:0] w_same;
    logic [3:0] w_pos;
    logic [3:0] w_bit;

    always_comb begin
        w_last   = (r_cnt == CW'(WORDS - 1));
        w_at_idx = (r_cnt == CW'(r_cmd.index));
        w_logic  = f_logic(r_cmd.func, r_src);
        w_add    = f_field_add(r_cmd.data);
        w_same   = 5'(DAM_WIDTH) - f_popcount(i_head ^ r_cmd.data);
        w_pos    = ~4'(r_cnt);
        w_bit    = ~r_cmd.index;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_cmd       = r_cmd;
        n_src       = r_src;
        n_acc       = r_acc;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_word  = r_hit_word;
        n_best_cnt  = r_best_cnt;
        n_best_idx  = r_best_idx;
        n_best_word = r_best_word;
        n_valid     = 1'b0;
        o_tail      = i_head;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd      = i_cmd;
                    n_state    = S_SCAN;
                    n_cnt      = '0;
                    n_pass     = 1'b0;
                    n_acc      = '0;
                    n_hit      = 1'b0;
                    n_hit_idx  = '0;
                    n_hit_word = '0;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CW'(1);
                case (r_cmd.operation)
                    OP_RD_WORD: begin
                        if (w_at_idx) begin
                            n_acc = i_head;
                        end
                    end
                    OP_WR_WORD: begin
                        if (w_at_idx) begin
                            o_tail = r_cmd.data;
                        end
                    end
                    OP_RD_SLICE: begin
                        n_acc[w_pos] = i_head[w_bit];
                    end
                    OP_WR_SLICE: begin
                        o_tail[w_bit] = r_cmd.data[w_pos];
                    end
                    OP_LOGIC: begin
                        if (!r_pass) begin
                            if (r_cnt == CW'(r_cmd.src_index)) begin
                                n_src = i_head;
                            end
                        end else if (w_at_idx) begin
                            o_tail = w_logic;
                        end
                    end
                    OP_KEY: begin
                        if (!r_hit && i_head[15:13] == r_cmd.key) begin
                            n_hit      = 1'b1;
                            n_hit_idx  = 4'(r_cnt);
                            n_hit_word = i_head;
                        end
                    end
                    OP_MATCH: begin
                        if (!r_hit && i_head == r_cmd.data) begin
                            n_hit      = 1'b1;
                            n_hit_idx  = 4'(r_cnt);
                            n_hit_word = i_head;
                        end
                        if (r_cnt == '0 || w_same > r_best_cnt) begin
                            n_best_cnt  = w_same;
                            n_best_idx  = 4'(r_cnt);
                            n_best_word = i_head;
                        end
                    end
                    OP_ADD: begin
                        if (!r_hit && i_head == r_cmd.data) begin
                            n_hit     = 1'b1;
                            n_hit_idx = 4'(r_cnt);
                            o_tail    = w_add;
                        end
                    end
                    default: begin
                    end
                endcase
                if (w_last) begin
                    if (r_cmd.operation == OP_LOGIC && !r_pass) begin
                        n_pass = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_result = '0;
        case (r_cmd.operation)
            OP_RD_WORD, OP_RD_SLICE: begin
                n_result.result_data = n_acc;
            end
            OP_WR_WORD, OP_WR_SLICE: begin
                n_result.result_data = r_cmd.data;
            end
            OP_LOGIC: begin
                n_result.result_data = w_logic;
            end
            OP_KEY: begin
                if (n_hit) begin
                    n_result.result_data  = n_hit_word;
                    n_result.result_index = n_hit_idx;
                    n_result.found        = 1'b1;
                end
            end
            OP_MATCH: begin
                if (n_hit) begin
                    n_result.result_data  = n_hit_word;
                    n_result.result_index = n_hit_idx;
                    n_result.found        = 1'b1;
                end else begin
                    n_result.result_data  = n_best_word;
                    n_result.result_index = n_best_idx;
                end
            end
            OP_ADD: begin
                n_result.result_data = w_add;
                if (n_hit) begin
                    n_result.result_index = n_hit_idx;
                    n_result.found        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_src       <= n_src;
        r_acc       <= n_acc;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_word  <= n_hit_word;
        r_best_cnt  <= n_best_cnt;
        r_best_idx  <= n_best_idx;
        r_best_word <= n_best_word;
        if (n_valid) begin
            r_result <= n_result;
        end
    end

    assign o_shift  = (r_state == S_SCAN);
    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_IDLE)
        else $error("result beat while a scan is running");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not start a scan");

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_cnt == '0)
        else $error("scan counter not back at the first word");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_result.found && r_cmd.operation != OP_MATCH)
            |-> r_result.result_index == '0)
        else $error("miss reports a nonzero word number");

    a_key_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_cmd.operation == OP_KEY && !r_result.found)
            |-> r_result.result_data == '0)
        else $error("key miss reports nonzero data");

endmodule
